[design/dpe_pkg.sv]
// shared constants and pipeline payload types for the dipole pair energy block
package dpe_pkg;

  localparam int POS_FRAC_BITS_DEF    = 8;
  localparam int MOMENT_FRAC_BITS_DEF = 14;

  localparam int SQRT_CELLS = 25;
  localparam int DIV_CELLS  = 33;

  localparam logic [32:0] NEG_LIMIT = 33'h080000000;
  localparam logic [32:0] POS_LIMIT = 33'h07FFFFFFF;

  // payload handed from one square root cell to the next
  typedef struct packed {
    logic        vld;
    logic        zero;
    logic        neg;
    logic [72:0] mag;
    logic [67:0] r2sq;
    logic [49:0] x;
    logic [26:0] rem;
    logic [24:0] root;
  } sq_t;

  // payload handed from one divider cell to the next
  typedef struct packed {
    logic        vld;
    logic        zero;
    logic        neg;
    logic        over;
    logic [92:0] den;
    logic [92:0] rem;
    logic [32:0] low;
    logic [32:0] q;
  } dv_t;

endpackage

[design/dpe_if.sv]
// channel interfaces for the pair input and the energy result
interface dpe_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] first_pos_x, first_pos_y, first_pos_z;
  logic signed [15:0] second_pos_x, second_pos_y, second_pos_z;
  logic signed [15:0] first_moment_x, first_moment_y, first_moment_z;
  logic signed [15:0] second_moment_x, second_moment_y, second_moment_z;
  modport source(output valid, first_pos_x, first_pos_y, first_pos_z, second_pos_x,
                 second_pos_y, second_pos_z, first_moment_x, first_moment_y,
                 first_moment_z, second_moment_x, second_moment_y, second_moment_z,
                 input ready);
  modport sink(input valid, first_pos_x, first_pos_y, first_pos_z, second_pos_x,
               second_pos_y, second_pos_z, first_moment_x, first_moment_y,
               first_moment_z, second_moment_x, second_moment_y, second_moment_z,
               output ready);
endinterface

interface dpe_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] energy;
  logic zero_distance;
  logic saturated;
  modport source(output valid, energy, zero_distance, saturated, input ready);
  modport sink(input valid, energy, zero_distance, saturated, output ready);
endinterface

[design/dipole_pair_energy.sv]
// top level: magnetic dipole pair energy, one pair per cycle while results are taken
//
//   channel  dir  handshake      payload
//   pair     in   valid/ready    two positions Q8.8, two moments Q2.14
//   result   out  valid/ready    energy Q16.16, zero_distance, saturated
//   cfg      in   cfg_we         three_dimensional (cfg_wdata)
//
// one pair per cycle while results are taken; each pair passes the front
// stages, 25 square root cells, 33 divider cells and the back stages.
// reset clears all stage valid bits and the mode register (2d).
// a stalled result freezes the whole chain; bubbles still move while the
// output register is empty.
module dipole_pair_energy
  import dpe_pkg::*;
#(
  parameter int POS_FRAC_BITS    = POS_FRAC_BITS_DEF,
  parameter int MOMENT_FRAC_BITS = MOMENT_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  dpe_in_if.sink     pair,
  dpe_out_if.source  result
);

  localparam int QS = 3 * POS_FRAC_BITS - 2 * MOMENT_FRAC_BITS + 24;
  localparam int NW = 73 + QS;

  logic three_dimensional;
  logic adv;

  sq_t sq [0:SQRT_CELLS];
  dv_t dv [0:DIV_CELLS];

  assign adv = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      three_dimensional <= 1'b0;
    end else if (cfg_we) begin
      three_dimensional <= cfg_wdata;
    end
  end

  dpe_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .three_d(three_dimensional),
    .pair(pair), .sq_out(sq[0])
  );

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    dpe_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv), .sq_in(sq[i]), .sq_out(sq[i+1])
    );
  end

  // denominator r2^2 * r in partial products
  logic        v_g, v_h;
  logic        zero_g, neg_g, zero_h, neg_h;
  logic [72:0] mag_g, mag_h;
  logic [41:0] pp0_g, pp1_g, pp2_g, pp3_g;
  logic [92:0] den_h;
  logic [NW-1:0] num_sh;
  logic [93:0]   hi_ext;

  assign num_sh = {mag_h, {QS{1'b0}}};
  assign hi_ext = 94'(num_sh[NW-1:33]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_g <= 1'b0;
      v_h <= 1'b0;
      dv[0].vld <= 1'b0;
    end else if (adv) begin
      v_g <= sq[SQRT_CELLS].vld;
      v_h <= v_g;
      dv[0].vld <= v_h;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_g <= sq[SQRT_CELLS].zero;
      neg_g  <= sq[SQRT_CELLS].neg;
      mag_g  <= sq[SQRT_CELLS].mag;
      pp0_g  <= sq[SQRT_CELLS].r2sq[16:0]  * sq[SQRT_CELLS].root;
      pp1_g  <= sq[SQRT_CELLS].r2sq[33:17] * sq[SQRT_CELLS].root;
      pp2_g  <= sq[SQRT_CELLS].r2sq[50:34] * sq[SQRT_CELLS].root;
      pp3_g  <= sq[SQRT_CELLS].r2sq[67:51] * sq[SQRT_CELLS].root;

      zero_h <= zero_g;
      neg_h  <= neg_g;
      mag_h  <= mag_g;
      den_h  <= 93'(pp0_g) + (93'(pp1_g) << 17) + (93'(pp2_g) << 34)
              + (93'(pp3_g) << 51);

      // quotient needs 33 bits; anything at or above 2^33 saturates
      dv[0].zero <= zero_h;
      dv[0].neg  <= neg_h;
      dv[0].over <= (hi_ext >= {1'b0, den_h});
      dv[0].den  <= den_h;
      dv[0].rem  <= (hi_ext >= {1'b0, den_h}) ? '0 : hi_ext[92:0];
      dv[0].low  <= num_sh[32:0];
      dv[0].q    <= '0;
    end
  end

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    dpe_div_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv), .dv_in(dv[j]), .dv_out(dv[j+1])
    );
  end

  // saturation and output register
  dv_t         fin;
  logic        sat_next;
  logic [31:0] energy_next;

  assign fin = dv[DIV_CELLS];

  always_comb begin
    sat_next    = 1'b0;
    energy_next = '0;
    if (fin.zero) begin
      energy_next = '0;
    end else if (fin.neg) begin
      if (fin.over || fin.q > NEG_LIMIT) begin
        sat_next    = 1'b1;
        energy_next = 32'h80000000;
      end else begin
        energy_next = 32'(-fin.q);
      end
    end else begin
      if (fin.over || fin.q > POS_LIMIT) begin
        sat_next    = 1'b1;
        energy_next = 32'h7FFFFFFF;
      end else begin
        energy_next = fin.q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.energy        <= $signed(energy_next);
      result.zero_distance <= fin.zero;
      result.saturated     <= sat_next;
    end
  end

endmodule

[design/dpe_front.sv]
// front pipeline: separation, dot products, r squared, numerator and r2 squared
module dpe_front
  import dpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       three_d,
  dpe_in_if.sink     pair,
  output sq_t        sq_out
);

  logic v_a, v_b, v_c, v_d, v_e, v_f;

  logic signed [16:0] dx_a, dy_a, dz_a;
  logic signed [15:0] ax_a, ay_a, az_a, bx_a, by_a, bz_a;

  logic signed [33:0] sxx_b, syy_b, szz_b;
  logic signed [31:0] mxx_b, myy_b, mzz_b;
  logic signed [32:0] pax_b, pay_b, paz_b, pbx_b, pby_b, pbz_b;

  logic [33:0]        r2_c;
  logic signed [33:0] dotm_c;
  logic signed [34:0] pa_c, pb_c;

  logic [33:0]        r2_d;
  logic signed [51:0] m1l_d, m1h_d, th_d;
  logic signed [53:0] tl_d;
  logic [50:0]        sl_d, sh_d;

  logic [33:0]        r2_e;
  logic signed [69:0] p1_e, t_e;
  logic [67:0]        r2sq_e;

  logic [33:0]        r2_f;
  logic signed [72:0] num_f;
  logic [67:0]        r2sq_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
      sq_out.vld <= 1'b0;
    end else if (adv) begin
      v_a <= pair.valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
      v_f <= v_e;
      sq_out.vld <= v_f;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // separation and z masking
      dx_a <= $signed({pair.second_pos_x[15], pair.second_pos_x})
            - $signed({pair.first_pos_x[15], pair.first_pos_x});
      dy_a <= $signed({pair.second_pos_y[15], pair.second_pos_y})
            - $signed({pair.first_pos_y[15], pair.first_pos_y});
      dz_a <= three_d ? $signed({pair.second_pos_z[15], pair.second_pos_z})
            - $signed({pair.first_pos_z[15], pair.first_pos_z}) : '0;
      ax_a <= pair.first_moment_x;
      ay_a <= pair.first_moment_y;
      az_a <= three_d ? pair.first_moment_z : '0;
      bx_a <= pair.second_moment_x;
      by_a <= pair.second_moment_y;
      bz_a <= three_d ? pair.second_moment_z : '0;

      sxx_b <= dx_a * dx_a;
      syy_b <= dy_a * dy_a;
      szz_b <= dz_a * dz_a;
      mxx_b <= ax_a * bx_a;
      myy_b <= ay_a * by_a;
      mzz_b <= az_a * bz_a;
      pax_b <= ax_a * dx_a;
      pay_b <= ay_a * dy_a;
      paz_b <= az_a * dz_a;
      pbx_b <= bx_a * dx_a;
      pby_b <= by_a * dy_a;
      pbz_b <= bz_a * dz_a;

      r2_c   <= {1'b0, sxx_b[32:0]} + {1'b0, syy_b[32:0]} + {1'b0, szz_b[32:0]};
      dotm_c <= 34'(mxx_b) + 34'(myy_b) + 34'(mzz_b);
      pa_c   <= 35'(pax_b) + 35'(pay_b) + 35'(paz_b);
      pb_c   <= 35'(pbx_b) + 35'(pby_b) + 35'(pbz_b);

      // wide products split into partial products
      r2_d  <= r2_c;
      m1l_d <= dotm_c * $signed({1'b0, r2_c[16:0]});
      m1h_d <= dotm_c * $signed({1'b0, r2_c[33:17]});
      tl_d  <= pa_c * $signed({1'b0, pb_c[17:0]});
      th_d  <= pa_c * $signed(pb_c[34:18]);
      sl_d  <= r2_c * r2_c[16:0];
      sh_d  <= r2_c * r2_c[33:17];

      r2_e   <= r2_d;
      p1_e   <= (70'(m1h_d) <<< 17) + 70'(m1l_d);
      t_e    <= (70'(th_d) <<< 18) + 70'(tl_d);
      r2sq_e <= {sh_d, 17'b0} + 68'(sl_d);

      r2_f   <= r2_e;
      r2sq_f <= r2sq_e;
      num_f  <= 73'(p1_e) - ((73'(t_e) <<< 1) + 73'(t_e));

      sq_out.zero <= (r2_f == '0);
      sq_out.neg  <= num_f[72];
      sq_out.mag  <= num_f[72] ? 73'(-num_f) : 73'(num_f);
      sq_out.r2sq <= r2sq_f;
      sq_out.x    <= {r2_f, 16'b0};
      sq_out.rem  <= '0;
      sq_out.root <= '0;
    end
  end

  assign pair.ready = adv;

endmodule

[design/dpe_sqrt_cell.sv]
// one square root cell: resolves one root bit and passes the rest on
module dpe_sqrt_cell
  import dpe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  sq_t  sq_in,
  output sq_t  sq_out
);

  logic [28:0] rem_sh;
  logic [28:0] trial;
  logic        take;

  assign rem_sh = {sq_in.rem, sq_in.x[49:48]};
  assign trial  = {2'b00, sq_in.root, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_out.vld <= 1'b0;
    end else if (adv) begin
      sq_out.vld <= sq_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_out.zero <= sq_in.zero;
      sq_out.neg  <= sq_in.neg;
      sq_out.mag  <= sq_in.mag;
      sq_out.r2sq <= sq_in.r2sq;
      sq_out.x    <= {sq_in.x[47:0], 2'b00};
      sq_out.rem  <= take ? 27'(rem_sh - trial) : rem_sh[26:0];
      sq_out.root <= {sq_in.root[23:0], take};
    end
  end

endmodule

[design/dpe_div_cell.sv]
// one divider cell: restoring step for one quotient bit
module dpe_div_cell
  import dpe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  dv_t  dv_in,
  output dv_t  dv_out
);

  logic [93:0] rem_sh;
  logic        take;

  assign rem_sh = {dv_in.rem, dv_in.low[32]};
  assign take   = (rem_sh >= {1'b0, dv_in.den});

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_out.vld <= 1'b0;
    end else if (adv) begin
      dv_out.vld <= dv_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_out.zero <= dv_in.zero;
      dv_out.neg  <= dv_in.neg;
      dv_out.over <= dv_in.over;
      dv_out.den  <= dv_in.den;
      dv_out.rem  <= take ? 93'(rem_sh - {1'b0, dv_in.den}) : rem_sh[92:0];
      dv_out.low  <= {dv_in.low[31:0], 1'b0};
      dv_out.q    <= {dv_in.q[31:0], take};
    end
  end

endmodule

[verif/dpe_checker.sv]
// checker: watches both channels, predicts the pair energy and compares results
module dpe_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  dpe_in_if    pair,
  dpe_out_if   result,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic signed [31:0] energy;
    logic               zero_distance;
    logic               saturated;
  } energy_t;

  energy_t expected_energies[$];
  bit      mode_3d;
  int      mismatches;

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res;
    res = 0;
    for (int i = 26; i >= 0; i--) begin
      if ((res | (64'd1 << i)) * (res | (64'd1 << i)) <= x) res = res | (64'd1 << i);
    end
    return res;
  endfunction

  function automatic energy_t pair_energy(logic signed [15:0] fpx, fpy, fpz, spx, spy, spz,
                                          fmx, fmy, fmz, smx, smy, smz, bit use_z);
    energy_t e;
    longint dx, dy, dz, ax, ay, az, bx, by, bz, r2, dotm, pa, pb;
    longint unsigned r;
    logic signed [127:0] num;
    logic [127:0] mag, den, q;
    dx = longint'(spx) - longint'(fpx);
    dy = longint'(spy) - longint'(fpy);
    dz = use_z ? longint'(spz) - longint'(fpz) : 0;
    ax = fmx; ay = fmy; az = use_z ? longint'(fmz) : 0;
    bx = smx; by = smy; bz = use_z ? longint'(smz) : 0;
    r2 = dx * dx + dy * dy + dz * dz;
    e = '0;
    if (r2 == 0) begin
      e.zero_distance = 1'b1;
      return e;
    end
    r = root_floor(longint'(r2) << 16);
    dotm = ax * bx + ay * by + az * bz;
    pa = ax * dx + ay * dy + az * dz;
    pb = bx * dx + by * dy + bz * dz;
    num = 128'(signed'(dotm)) * 128'(signed'(r2))
          - 128'(signed'(3)) * 128'(signed'(pa)) * 128'(signed'(pb));
    mag = num[127] ? 128'(-num) : 128'(num);
    mag = mag << 20;
    den = 128'(r2) * 128'(r2) * 128'(r);
    q = mag / den;
    if (num[127]) begin
      if (q > 128'h80000000) begin
        e.saturated = 1'b1;
        q = 128'h80000000;
      end
      e.energy = 32'(-q[31:0]);
    end else begin
      if (q > 128'h7FFFFFFF) begin
        e.saturated = 1'b1;
        q = 128'h7FFFFFFF;
      end
      e.energy = q[31:0];
    end
    return e;
  endfunction

  assign pending = expected_energies.size();
  assign errors  = mismatches;

  always @(posedge clk) begin
    energy_t want;
    if (rst) begin
      mode_3d <= 1'b0;
    end else begin
      if (cfg_we) mode_3d <= cfg_wdata;
      if (pair.valid && pair.ready)
        expected_energies.push_back(pair_energy(pair.first_pos_x, pair.first_pos_y,
          pair.first_pos_z, pair.second_pos_x, pair.second_pos_y, pair.second_pos_z,
          pair.first_moment_x, pair.first_moment_y, pair.first_moment_z,
          pair.second_moment_x, pair.second_moment_y, pair.second_moment_z, mode_3d));
      if (result.valid && result.ready) begin
        if (expected_energies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer energy=%0d", result.energy);
        end else begin
          want = expected_energies.pop_front();
          if (result.energy !== want.energy || result.zero_distance !== want.zero_distance ||
              result.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected energy=%0d zero=%0b sat=%0b, got %0d %0b %0b",
                       want.energy, want.zero_distance, want.saturated,
                       result.energy, result.zero_distance, result.saturated);
          end
        end
      end
    end
  end

endmodule

[verif/dipole_pair_energy_test.sv]
// testbench top: stimulus, mode changes, idling and verdict for the pair energy block
module dipole_pair_energy_test;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  int   errors;
  int   pending;
  int   tx_idle;
  int   rx_idle;
  int   quiet_cycles;

  dpe_in_if  pair();
  dpe_out_if result();

  dipole_pair_energy i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pair(pair), .result(result)
  );

  dpe_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pair(pair), .result(result), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(negedge clk) result.ready <= ($urandom_range(99) >= rx_idle);

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (pair.valid && pair.ready) || (result.valid && result.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("[dipole_pair_energy] ERROR");
      $finish;
    end
  end

  task automatic send_pair(logic [11:0][15:0] v);
    while ($urandom_range(99) < tx_idle) begin
      pair.valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    {pair.first_pos_x, pair.first_pos_y, pair.first_pos_z,
     pair.second_pos_x, pair.second_pos_y, pair.second_pos_z,
     pair.first_moment_x, pair.first_moment_y, pair.first_moment_z,
     pair.second_moment_x, pair.second_moment_y, pair.second_moment_z} <= v;
    pair.valid <= 1'b1;
    @(posedge clk);
    while (!pair.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle_and_write(bit mode);
    pair.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic directed_pairs();
    logic [11:0][15:0] v;
    send_pair('0);                                     // coinciding at origin
    send_pair({6{16'h7FFF, 16'h8000}});
    send_pair({{3{16'h8000}}, {3{16'h7FFF}}, {6{16'h7FFF}}});
    send_pair({{3{16'h8000}}, {3{16'h7FFF}}, {6{16'h8000}}});
    send_pair({{3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}});
    // same x and y, different z: coinciding only in 2d
    send_pair({16'h0100, 16'h0200, 16'h0000, 16'h0100, 16'h0200, 16'h0500,
               {6{16'h4000}}});
    // one lsb apart with large moments: the energy saturates or comes out zero
    send_pair({16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
               {6{16'h7FFF}}});
    send_pair({16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
               16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000});
    send_pair({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
               {3{16'h7FFF}}, {3{16'h8000}}});
    // unit separation, unit moments along and across it
    send_pair({16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
               16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000});
    send_pair({16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
               16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000});
    send_pair({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
               16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'hC000});
    for (int i = 0; i < 6; i++) begin
      v = {12{16'hFFFF}};
      v[11 - i] = 16'h0000;
      send_pair(v);
    end
  endtask

  task automatic random_pairs(int count);
    logic [11:0][15:0] v;
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 12; k++) v[k] = 16'($urandom);
      // mostly nearby pairs so the quotient stays in range
      if ($urandom_range(99) < 70)
        for (int k = 0; k < 3; k++)
          v[8 - k] = v[11 - k] + 16'($signed($urandom_range(0, 4096)) - 2048);
      if ($urandom_range(99) < 5) v[8:6] = v[11:9];
      send_pair(v);
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    pair.valid   = 1'b0;
    pair.first_pos_x = '0;  pair.first_pos_y = '0;  pair.first_pos_z = '0;
    pair.second_pos_x = '0; pair.second_pos_y = '0; pair.second_pos_z = '0;
    pair.first_moment_x = '0;  pair.first_moment_y = '0;  pair.first_moment_z = '0;
    pair.second_moment_x = '0; pair.second_moment_y = '0; pair.second_moment_z = '0;
    result.ready = 1'b0;
    tx_idle      = 24;
    rx_idle      = 46;
    quiet_cycles = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_pairs();
    for (int phase = 0; phase < 6; phase++) begin
      tx_idle = (phase < 2) ? 24 : (phase < 4) ? 46 : 0;
      rx_idle = (phase < 2) ? 46 : (phase < 4) ? 24 : 0;
      settle_and_write(phase[0] ^ 1'b1);
      if (phase == 0) directed_pairs();
      random_pairs(300);
    end
    pair.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("[dipole_pair_energy] OK");
    end else begin
      $display("[dipole_pair_energy] ERROR");
    end
    $finish;
  end

endmodule
